@@ hw/rtl/ttyld_pkg.sv @@
`timescale 1ns / 1ps
// package for the tty line discipline: buffer depth, derived widths,
// character and opcode codes, result record type. no dependencies.
package ttyld_pkg;

   localparam int BUF_DEPTH = 128;
   localparam int PTR_W     = $clog2(BUF_DEPTH);
   localparam int CNT_W     = $clog2(BUF_DEPTH + 1);
   localparam int CHAR_W    = 8;

   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(BUF_DEPTH);
   localparam logic [CNT_W:0]   DEPTH_X = (CNT_W + 1)'(BUF_DEPTH);

   localparam logic [CHAR_W-1:0] CH_NUL       = 8'd0;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;

   localparam logic OP_KEY  = 1'b0;
   localparam logic OP_READ = 1'b1;

   typedef struct packed {
      logic              echo_valid;
      logic [CHAR_W-1:0] echo_char;
      logic              line_committed;
      logic              read_valid;
      logic [CHAR_W-1:0] read_char;
      logic              dropped;
   } rsp_data_type;

endpackage

@@ hw/rtl/ttyld_if.sv @@
`timescale 1ns / 1ps
// valid/ready channel interfaces for the tty line discipline
// depends on ttyld_pkg
interface ttyld_req_if import ttyld_pkg::*;;
   logic              valid;
   logic              ready;
   logic              opcode;
   logic [CHAR_W-1:0] key_char;

   modport source (output valid, output opcode, output key_char, input ready);
   modport sink   (input valid, input opcode, input key_char, output ready);
endinterface

interface ttyld_rsp_if import ttyld_pkg::*;;
   logic              valid;
   logic              ready;
   logic              echo_valid;
   logic [CHAR_W-1:0] echo_char;
   logic              line_committed;
   logic              read_valid;
   logic [CHAR_W-1:0] read_char;
   logic              dropped;

   modport source (output valid, output echo_valid, output echo_char,
                   output line_committed, output read_valid, output read_char,
                   output dropped, input ready);
   modport sink   (input valid, input echo_valid, input echo_char,
                   input line_committed, input read_valid, input read_char,
                   input dropped, output ready);
endinterface

@@ hw/rtl/ttyld_ram.sv @@
`timescale 1ns / 1ps
// simple dual-port ram, one write port and one registered read port
// no dependencies
module ttyld_ram #(
   parameter int DEPTH = 128,
   parameter int WIDTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/tty_line_discipline.sv @@
`timescale 1ns / 1ps
// canonical-mode tty line buffer: edit line ram, read fifo ram, control fsm
// depends on ttyld_pkg, ttyld_if, ttyld_ram
//
// Handles one transaction at a time. A key transaction's result passes
// through the pend register and then the output register; a read passes
// first through the registered read of the read fifo ram. A key that ends a
// line (newline, or the line reaching BUF_DEPTH characters) copies the edit
// line into the read fifo one character per cycle through the two rams. A
// finished result sits in an output register, so the next transaction is
// taken while it waits for rsp ready.
// Characters that do not fit in a full read fifo are lost and flagged with
// dropped. Both rams hold garbage after reset and need no clearing.
module tty_line_discipline import ttyld_pkg::*; (
   input logic          clock,
   input logic          reset,
   ttyld_req_if.sink    req,
   ttyld_rsp_if.source  rsp
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_COMMIT = 2'd1;
   localparam logic [1:0] S_READ   = 2'd2;
   localparam logic [1:0] S_EMIT   = 2'd3;

   function automatic logic [PTR_W-1:0] wrap_ptr(input logic [CNT_W:0] s);
      logic [CNT_W:0] r;
      r = (s >= DEPTH_X) ? s - DEPTH_X : s;
      return r[PTR_W-1:0];
   endfunction

   logic [1:0]       state_ff, state_in;
   logic [PTR_W-1:0] edit_start_ff, edit_start_in;
   logic [CNT_W-1:0] edit_count_ff, edit_count_in;
   logic [PTR_W-1:0] read_head_ff, read_head_in;
   logic [CNT_W-1:0] read_count_ff, read_count_in;
   logic             pipe_v_ff, pipe_v_in;
   rsp_data_type     pend_ff, pend_in;
   rsp_data_type     out_ff, out_in;
   logic             out_valid_ff, out_valid_in;

   logic              edit_wr_en;
   logic [PTR_W-1:0]  edit_wr_addr;
   logic              edit_rd_en;
   logic [CHAR_W-1:0] edit_rd_data;
   logic              read_wr_en;
   logic [PTR_W-1:0]  read_wr_addr;
   logic              read_rd_en;
   logic [CHAR_W-1:0] read_rd_data;

   logic             accept;
   logic [CNT_W-1:0] count_nx;
   logic [CNT_W:0]   start_x;
   logic [CNT_W:0]   head_x;

   assign req.ready = (state_ff == S_IDLE);
   assign accept    = req.valid && req.ready;
   assign start_x   = {{(CNT_W + 1 - PTR_W){1'b0}}, edit_start_ff};
   assign head_x    = {{(CNT_W + 1 - PTR_W){1'b0}}, read_head_ff};

   always_comb begin
      state_in      = state_ff;
      edit_start_in = edit_start_ff;
      edit_count_in = edit_count_ff;
      read_head_in  = read_head_ff;
      read_count_in = read_count_ff;
      pipe_v_in     = 1'b0;
      pend_in       = pend_ff;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff && !rsp.ready;
      edit_wr_en    = 1'b0;
      edit_wr_addr  = wrap_ptr(start_x + {1'b0, edit_count_ff});
      edit_rd_en    = 1'b0;
      read_wr_en    = 1'b0;
      read_wr_addr  = wrap_ptr(head_x + {1'b0, read_count_ff});
      read_rd_en    = 1'b0;
      count_nx      = edit_count_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pend_in  = '0;
               state_in = S_EMIT;
               if (req.opcode == OP_KEY) begin
                  if (!(req.key_char == CH_BACKSPACE && edit_count_ff == '0)) begin
                     pend_in.echo_valid = 1'b1;
                     pend_in.echo_char  = req.key_char;
                     if (req.key_char != CH_NUL) begin
                        if (req.key_char == CH_BACKSPACE) begin
                           count_nx = edit_count_ff - 1'b1;
                        end else if (edit_count_ff < DEPTH_C) begin
                           edit_wr_en = 1'b1;
                           count_nx   = edit_count_ff + 1'b1;
                        end
                        edit_count_in = count_nx;
                        if (count_nx >= DEPTH_C || req.key_char == CH_NEWLINE) begin
                           pend_in.line_committed = 1'b1;
                           state_in               = S_COMMIT;
                        end
                     end
                  end
               end else if (read_count_ff != '0) begin
                  read_rd_en         = 1'b1;
                  read_head_in       = wrap_ptr(head_x + 1'b1);
                  read_count_in      = read_count_ff - 1'b1;
                  pend_in.read_valid = 1'b1;
                  state_in           = S_READ;
               end
            end
         end
         S_COMMIT: begin
            if (edit_count_ff != '0) begin
               edit_rd_en    = 1'b1;
               pipe_v_in     = 1'b1;
               edit_start_in = wrap_ptr(start_x + 1'b1);
               edit_count_in = edit_count_ff - 1'b1;
            end
            if (pipe_v_ff) begin
               if (read_count_ff != DEPTH_C) begin
                  read_wr_en    = 1'b1;
                  read_count_in = read_count_ff + 1'b1;
               end else begin
                  pend_in.dropped = 1'b1;
               end
            end
            if (edit_count_ff == '0 && !pipe_v_ff) begin
               state_in = S_EMIT;
            end
         end
         S_READ: begin
            pend_in.read_char = read_rd_data;
            state_in          = S_EMIT;
         end
         S_EMIT: begin
            if (!out_valid_ff || rsp.ready) begin
               out_in       = pend_ff;
               out_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         edit_start_ff <= '0;
         edit_count_ff <= '0;
         read_head_ff  <= '0;
         read_count_ff <= '0;
         pipe_v_ff     <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         edit_start_ff <= edit_start_in;
         edit_count_ff <= edit_count_in;
         read_head_ff  <= read_head_in;
         read_count_ff <= read_count_in;
         pipe_v_ff     <= pipe_v_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
      out_ff  <= out_in;
   end

   ttyld_ram #(
      .DEPTH (BUF_DEPTH),
      .WIDTH (CHAR_W)
   ) u_edit_ram (
      .clock   (clock),
      .wr_en   (edit_wr_en),
      .wr_addr (edit_wr_addr),
      .wr_data (req.key_char),
      .rd_en   (edit_rd_en),
      .rd_addr (edit_start_ff),
      .rd_data (edit_rd_data)
   );

   ttyld_ram #(
      .DEPTH (BUF_DEPTH),
      .WIDTH (CHAR_W)
   ) u_read_ram (
      .clock   (clock),
      .wr_en   (read_wr_en),
      .wr_addr (read_wr_addr),
      .wr_data (edit_rd_data),
      .rd_en   (read_rd_en),
      .rd_addr (read_head_ff),
      .rd_data (read_rd_data)
   );

   assign rsp.valid          = out_valid_ff;
   assign rsp.echo_valid     = out_ff.echo_valid;
   assign rsp.echo_char      = out_ff.echo_char;
   assign rsp.line_committed = out_ff.line_committed;
   assign rsp.read_valid     = out_ff.read_valid;
   assign rsp.read_char      = out_ff.read_char;
   assign rsp.dropped        = out_ff.dropped;

endmodule
